// File: rtl/core/macf_pkg.sv
// Package: shared constants and types for the moving average clamp filter.
`default_nettype none
package macf_pkg;

  localparam int LIMIT_W    = 12;
  localparam int WARM_W     = 6;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [LIMIT_W-1:0] LOWER_RST = 12'd25;
  localparam logic [LIMIT_W-1:0] UPPER_RST = 12'd300;
  localparam logic [WARM_W-1:0]  WARM_RST  = 6'd20;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LOWER  = 2'd0,
    REG_UPPER  = 2'd1,
    REG_WARMUP = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic shift_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/macf_if.sv
// Interfaces: sample-pair input channel and filtered result channel.
`default_nettype none
interface macf_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface macf_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_distance;
  logic [11:0] right_distance;
  logic        warmed_up;

  modport source (output valid, output left_distance, output right_distance,
                  output warmed_up, input ready);
  modport sink   (input valid, input left_distance, input right_distance,
                  input warmed_up, output ready);
endinterface
`default_nettype wire

// File: rtl/core/macf_tap_cell.sv
// Tap cell: holds one left and one right history sample, shifts to its neighbor.
`default_nettype none
module macf_tap_cell
  import macf_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [SAMPLE_BITS-1:0] left_in,
  input  wire logic [SAMPLE_BITS-1:0] right_in,
  output logic      [SAMPLE_BITS-1:0] left_q,
  output logic      [SAMPLE_BITS-1:0] right_q
);

  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (ctrl.shift_en) begin
      left_r  <= left_in;
      right_r <= right_in;
    end
  end

  assign left_q  = left_r;
  assign right_q = right_r;

endmodule
`default_nettype wire

// File: rtl/core/macf_div_unit.sv
// Divide-by-tap-count unit: reciprocal multiply, registered quotient.
`default_nettype none
module macf_div_unit
  import macf_pkg::*;
#(
  parameter int TAPS        = 20,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                                     clk,
  input  wire logic                                     load,
  input  wire logic [SAMPLE_BITS+$clog2(TAPS)-1:0]      sum,
  output logic      [SAMPLE_BITS-1:0]                   quot_r
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(TAPS);
  localparam int DIV_SH = SUM_W + $clog2(TAPS);
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  // ceil(2^DIV_SH / TAPS); exact floor for every sum below 2^SUM_W
  localparam longint unsigned DIV_MUL_L =
    ((64'd1 << DIV_SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= prod[DIV_SH +: SAMPLE_BITS];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/moving_average_clamp_filter.sv
// Top level: two-channel moving average with warm-up and output clamping.
//
// in_ch carries one left/right sample pair per transaction, out_ch one result
// per accepted input: two clamped distances and a warmed_up flag. Both use
// valid/ready; a transaction completes when valid and ready are both high.
// The first warmup_items inputs after reset leave the histories untouched and
// return lower_limit with warmed_up low. Later inputs shift into a row of TAPS
// tap cells per channel; a running sum (add newest, drop oldest) is divided by
// TAPS through a reciprocal multiply and clamped to [lower_limit, upper_limit].
// Three register stages (sums, quotient, clamp) lie between an input
// transaction and out_ch.valid. While out_ch is ready the block takes one
// transaction per cycle, set by the running-sum register and the single
// multiplier per channel. When out_ch stalls, the pipeline fills its bubbles
// and then holds in_ch.ready low; nothing is dropped. Reset (rst_n low,
// synchronous) clears histories, sums, warm-up count and all valid bits, and
// loads the registers with 25, 300, 20. The user must write registers over the
// APB port (byte addresses 0, 4, 8) only while the block is idle; unenforced.
`default_nettype none
module moving_average_clamp_filter
  import macf_pkg::*;
#(
  parameter int TAPS        = 20,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  macf_in_if.sink                    in_ch,
  macf_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(TAPS);
  localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;
  localparam logic [SUM_W-1:0] SUM_MAX =
    SUM_W'(TAPS) * SUM_W'({SAMPLE_BITS{1'b1}});

  // configuration registers
  logic [LIMIT_W-1:0] lower_r;
  logic [LIMIT_W-1:0] upper_r;
  logic [WARM_W-1:0]  warm_items_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // state
  logic [WARM_W-1:0]      warm_cnt_r;
  logic [SUM_W-1:0]       sum_l_r;
  logic [SUM_W-1:0]       sum_rt_r;
  logic [SUM_W-1:0]       sum_l_nxt;
  logic [SUM_W-1:0]       sum_rt_nxt;
  logic [SAMPLE_BITS-1:0] tap_l [TAPS];
  logic [SAMPLE_BITS-1:0] tap_rt [TAPS];
  cell_ctrl_t             cell_ctrl;

  // pipeline control
  logic in_fire;
  logic in_warm;
  logic s1_valid_r, s1_filt_r;
  logic s2_valid_r, s2_filt_r;
  logic out_valid_r;
  logic s1_free, s2_free, s3_free;
  logic s2_load;

  logic [SAMPLE_BITS-1:0] quot_l;
  logic [SAMPLE_BITS-1:0] quot_rt;
  logic [LIMIT_W-1:0]     dist_l_r, dist_rt_r;
  logic                   warmed_r;

  function automatic logic [LIMIT_W-1:0] clamp_dist(
    input logic [SAMPLE_BITS-1:0] q,
    input logic [LIMIT_W-1:0]     lo,
    input logic [LIMIT_W-1:0]     hi
  );
    logic [CMP_W-1:0] qx;
    logic [LIMIT_W-1:0] res;
    qx = CMP_W'(q);
    if (qx < CMP_W'(lo)) begin
      res = lo;
    end else if (qx > CMP_W'(hi)) begin
      res = hi;
    end else begin
      res = LIMIT_W'(qx);
    end
    return res;
  endfunction

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r      <= LOWER_RST;
      upper_r      <= UPPER_RST;
      warm_items_r <= WARM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOWER:  lower_r      <= cfg_pwdata[LIMIT_W-1:0];
        REG_UPPER:  upper_r      <= cfg_pwdata[LIMIT_W-1:0];
        REG_WARMUP: warm_items_r <= cfg_pwdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOWER:  cfg_prdata = APB_DATA_W'(lower_r);
      REG_UPPER:  cfg_prdata = APB_DATA_W'(upper_r);
      REG_WARMUP: cfg_prdata = APB_DATA_W'(warm_items_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- handshake / stage enables ----------------
  assign s3_free  = !out_valid_r || out_ch.ready;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s2_load  = s1_valid_r && s2_free;
  assign in_ch.ready = s1_free;
  assign in_fire  = in_ch.valid && s1_free;
  assign in_warm  = warm_cnt_r < warm_items_r;

  assign cell_ctrl.shift_en = in_fire && !in_warm;

  // ---------------- tap cell chain ----------------
  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    if (i == 0) begin : g_head
      macf_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .left_in  (in_ch.left_sample),
        .right_in (in_ch.right_sample),
        .left_q   (tap_l[i]),
        .right_q  (tap_rt[i])
      );
    end else begin : g_body
      macf_tap_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .left_in  (tap_l[i-1]),
        .right_in (tap_rt[i-1]),
        .left_q   (tap_l[i]),
        .right_q  (tap_rt[i])
      );
    end
  end

  // running window sums: add the newest sample, drop the one leaving the last cell
  assign sum_l_nxt  = sum_l_r + SUM_W'(in_ch.left_sample) - SUM_W'(tap_l[TAPS-1]);
  assign sum_rt_nxt = sum_rt_r + SUM_W'(in_ch.right_sample) - SUM_W'(tap_rt[TAPS-1]);

  // stage 1: warm-up count, sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
      sum_l_r    <= '0;
      sum_rt_r   <= '0;
      s1_valid_r <= 1'b0;
      s1_filt_r  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_ch.valid;
      end
      if (in_fire) begin
        s1_filt_r <= !in_warm;
        if (in_warm) begin
          warm_cnt_r <= WARM_W'(warm_cnt_r + 1'b1);
        end else begin
          sum_l_r  <= sum_l_nxt;
          sum_rt_r <= sum_rt_nxt;
        end
      end
    end
  end

  // stage 2: divide by TAPS
  macf_div_unit #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_div_l (
    .clk    (clk),
    .load   (s2_load),
    .sum    (sum_l_r),
    .quot_r (quot_l)
  );

  macf_div_unit #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_div_rt (
    .clk    (clk),
    .load   (s2_load),
    .sum    (sum_rt_r),
    .quot_r (quot_rt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_filt_r  <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        s2_filt_r <= s1_filt_r;
      end
    end
  end

  // stage 3: clamp into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid_r) begin
      warmed_r <= s2_filt_r;
      if (s2_filt_r) begin
        dist_l_r  <= clamp_dist(quot_l, lower_r, upper_r);
        dist_rt_r <= clamp_dist(quot_rt, lower_r, upper_r);
      end else begin
        dist_l_r  <= lower_r;
        dist_rt_r <= lower_r;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_distance  = dist_l_r;
  assign out_ch.right_distance = dist_rt_r;
  assign out_ch.warmed_up      = warmed_r;

  // ---------------- assertions ----------------
  a_warm_output_is_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.warmed_up |->
      out_ch.left_distance == lower_r && out_ch.right_distance == lower_r)
    else $error("warm-up result differs from lower limit");

  a_clamp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.warmed_up && lower_r <= upper_r |->
      out_ch.left_distance >= lower_r && out_ch.left_distance <= upper_r &&
      out_ch.right_distance >= lower_r && out_ch.right_distance <= upper_r)
    else $error("filtered result outside limits");

  a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sum_l_r <= SUM_MAX && sum_rt_r <= SUM_MAX)
    else $error("running sum exceeds full-scale window");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transaction lost in first stage");

endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the two-channel moving average clamp filter.
module testbench
  import macf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS         = 20;
  localparam int SAMPLE_BITS  = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 80;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;
  } sample_pair_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] left_distance;
    logic [LIMIT_W-1:0] right_distance;
    logic               warmed_up;
  } distance_pair_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pattern_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  macf_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  macf_out_if                             out_ch ();

  moving_average_clamp_filter #(
    .TAPS       (TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor state
  logic [LIMIT_W-1:0]     exp_lower;
  logic [LIMIT_W-1:0]     exp_upper;
  logic [WARM_W-1:0]      warm_items;
  logic [WARM_W-1:0]      warm_count;
  logic [SAMPLE_BITS-1:0] left_taps [TAPS];
  logic [SAMPLE_BITS-1:0] right_taps [TAPS];

  sample_pair_t   pending_pairs[$];
  distance_pair_t expected_distances[$];
  int unsigned    error_count;
  int unsigned    watchdog_cycles;
  bit             hold_off;
  int             burst_left;
  int             gap_left;
  int unsigned    rx_tick;
  rx_pattern_t    rx_pattern;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [LIMIT_W-1:0] clamp_distance(int unsigned mean);
    if (mean < exp_lower) return exp_lower;
    if (mean > exp_upper) return exp_upper;
    return LIMIT_W'(mean);
  endfunction

  // advances the predictor by one sample pair
  function automatic distance_pair_t predict_distances(logic [SAMPLE_BITS-1:0] left,
                                                       logic [SAMPLE_BITS-1:0] right);
    distance_pair_t res;
    int unsigned    lsum;
    int unsigned    rsum;
    int             i;
    if (warm_count < warm_items) begin
      warm_count         = warm_count + 1'b1;
      res.left_distance  = exp_lower;
      res.right_distance = exp_lower;
      res.warmed_up      = 1'b0;
    end else begin
      for (i = TAPS - 1; i > 0; i--) begin
        left_taps[i]  = left_taps[i-1];
        right_taps[i] = right_taps[i-1];
      end
      left_taps[0]  = left;
      right_taps[0] = right;
      lsum = 0;
      rsum = 0;
      for (i = 0; i < TAPS; i++) begin
        lsum += left_taps[i];
        rsum += right_taps[i];
      end
      res.left_distance  = clamp_distance(lsum / TAPS);
      res.right_distance = clamp_distance(rsum / TAPS);
      res.warmed_up      = 1'b1;
    end
    return res;
  endfunction

  // driver: bursts with random gaps, valid held until the transaction completes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.left_sample  <= '0;
      in_ch.right_sample <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_distances.push_back(predict_distances(in_ch.left_sample,
                                                       in_ch.right_sample));
        pending_pairs.delete(0);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0 && !hold_off) begin
          in_ch.valid        <= 1'b1;
          in_ch.left_sample  <= pending_pairs[0].left_sample;
          in_ch.right_sample <= pending_pairs[0].right_sample;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction, drives the stall pattern
  always @(posedge clk) begin
    distance_pair_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_tick    = 0;
      rx_pattern = RX_OPEN;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_distances.size() == 0) begin
          $error("unexpected result: left_distance %0d right_distance %0d warmed_up %0b",
                 out_ch.left_distance, out_ch.right_distance, out_ch.warmed_up);
          error_count++;
        end else begin
          want = expected_distances.pop_front();
          if (out_ch.left_distance !== want.left_distance) begin
            $error("left_distance: expected %0d, actual %0d",
                   want.left_distance, out_ch.left_distance);
            error_count++;
          end
          if (out_ch.right_distance !== want.right_distance) begin
            $error("right_distance: expected %0d, actual %0d",
                   want.right_distance, out_ch.right_distance);
            error_count++;
          end
          if (out_ch.warmed_up !== want.warmed_up) begin
            $error("warmed_up: expected %0b, actual %0b", want.warmed_up, out_ch.warmed_up);
            error_count++;
          end
        end
      end
      rx_tick++;
      if (rx_tick % 64 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      case (rx_pattern)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= (rx_tick % 4 == 0);
        default:   out_ch.ready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  initial begin
    watchdog_cycles = 0;
    while (watchdog_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      watchdog_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic apb_cycle(input logic wr, input reg_idx_t idx,
                           input logic [APB_DATA_W-1:0] wdata,
                           output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    case (idx)
      REG_LOWER: if (rd[LIMIT_W-1:0] !== exp_lower) begin
        $error("lower_limit readback: expected %0d, actual %0d", exp_lower, rd[LIMIT_W-1:0]);
        error_count++;
      end
      REG_UPPER: if (rd[LIMIT_W-1:0] !== exp_upper) begin
        $error("upper_limit readback: expected %0d, actual %0d", exp_upper, rd[LIMIT_W-1:0]);
        error_count++;
      end
      default: if (rd[WARM_W-1:0] !== warm_items) begin
        $error("warmup_items readback: expected %0d, actual %0d", warm_items, rd[WARM_W-1:0]);
        error_count++;
      end
    endcase
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    logic [APB_DATA_W-1:0] rd;
    apb_cycle(1'b1, idx, APB_DATA_W'(value), rd);
    case (idx)
      REG_LOWER: exp_lower  = LIMIT_W'(value);
      REG_UPPER: exp_upper  = LIMIT_W'(value);
      default:   warm_items = WARM_W'(value);
    endcase
    check_reg(idx);
  endtask

  task automatic queue_pair(input logic [SAMPLE_BITS-1:0] left,
                            input logic [SAMPLE_BITS-1:0] right);
    sample_pair_t p;
    p.left_sample  = left;
    p.right_sample = right;
    pending_pairs.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_ch.valid || expected_distances.size() != 0);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'($urandom_range(0, 600));
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // mostly steady runs long enough to fill the window, some noise and toggling;
  // warm-up items come on top of the filtered count
  task automatic queue_random_items(input int unsigned n_filtered);
    int unsigned            total;
    int unsigned            run_len;
    int unsigned            i;
    logic [SAMPLE_BITS-1:0] lbase;
    logic [SAMPLE_BITS-1:0] rbase;
    total = n_filtered + ((warm_items > warm_count) ? warm_items - warm_count : 0);
    while (total > 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          run_len = $urandom_range(1, 12);
          for (i = 0; i < run_len && total > 0; i++, total--)
            queue_pair(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
        end
        2: begin
          run_len = $urandom_range(2, 24);
          for (i = 0; i < run_len && total > 0; i++, total--)
            queue_pair(i[0] ? '1 : '0, i[0] ? '0 : '1);
        end
        default: begin
          lbase   = pick_level();
          rbase   = pick_level();
          run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 19) : $urandom_range(20, 40);
          for (i = 0; i < run_len && total > 0; i++, total--)
            queue_pair(lbase ^ SAMPLE_BITS'($urandom_range(0, 7)),
                       rbase ^ SAMPLE_BITS'($urandom_range(0, 7)));
        end
      endcase
    end
  endtask

  initial begin
    int unsigned lo;
    int unsigned phase;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    hold_off     = 1'b0;
    error_count  = 0;
    exp_lower    = LOWER_RST;
    exp_upper    = UPPER_RST;
    warm_items   = WARM_RST;
    warm_count   = '0;
    for (int i = 0; i < TAPS; i++) begin
      left_taps[i]  = '0;
      right_taps[i] = '0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    check_reg(REG_LOWER);
    check_reg(REG_UPPER);
    check_reg(REG_WARMUP);

    // zero warm-up: first item after reset is already filtered, reset limits
    write_reg(REG_WARMUP, 0);
    @(negedge clk);
    queue_pair('1, '0);
    queue_pair('0, '1);
    queue_pair('1, '1);
    queue_pair('1, '1);
    queue_pair('1, '1);
    queue_pair(12'haaa, 12'h555);
    queue_pair(12'h555, 12'haaa);
    queue_pair('0, '0);
    queue_pair(12'd1, 12'd2048);
    wait_idle();

    // crossed limits
    write_reg(REG_LOWER, 200);
    write_reg(REG_UPPER, 100);
    @(negedge clk);
    queue_pair('0, '0);
    queue_pair('1, '1);
    queue_pair('1, '0);
    queue_pair(12'd2000, 12'd3000);
    queue_pair('0, '0);
    queue_pair('1, '1);
    wait_idle();

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin
          // larger warm-up count resumes warm-up
          write_reg(REG_LOWER, 0);
          write_reg(REG_UPPER, 4095);
          write_reg(REG_WARMUP, 12);
        end
        1: begin
          // smaller warm-up count ends it at once
          write_reg(REG_LOWER, 4095);
          write_reg(REG_UPPER, 0);
          write_reg(REG_WARMUP, 5);
        end
        2: begin
          lo = $urandom_range(0, 600);
          write_reg(REG_LOWER, lo);
          write_reg(REG_UPPER, lo);
        end
        8: begin
          write_reg(REG_LOWER, LOWER_RST);
          write_reg(REG_UPPER, UPPER_RST);
          write_reg(REG_WARMUP, 63);
        end
        default: begin
          lo = $urandom_range(0, 500);
          write_reg(REG_LOWER, lo);
          write_reg(REG_UPPER, $urandom_range(0, 1) ? $urandom_range(lo, 4095)
                                                    : $urandom_range(0, 4095));
          case ($urandom_range(0, 2))
            0:       write_reg(REG_WARMUP, (warm_count + $urandom_range(1, 8) > 63) ? 63
                                           : warm_count + $urandom_range(1, 8));
            1:       write_reg(REG_WARMUP, 0);
            default: write_reg(REG_WARMUP, $urandom_range(0, 63));
          endcase
        end
      endcase
      @(negedge clk);
      queue_random_items(PHASE_ITEMS);
      if (phase == 3) begin
        // hold the sender until the pipeline has fully drained
        do @(negedge clk); while (pending_pairs.size() > PHASE_ITEMS / 2);
        hold_off = 1'b1;
        do @(negedge clk); while (in_ch.valid || expected_distances.size() != 0);
        hold_off = 1'b0;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
